FILE: rtl/rtt_ewma_estimator_macros.svh
// assertion macros shared by the rtt estimator checker
// expects clk and arst_n in the scope where a macro is used
`ifndef RTT_EWMA_ESTIMATOR_MACROS_SVH
`define RTT_EWMA_ESTIMATOR_MACROS_SVH

// same-cycle implication, off during reset
`define RTT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtt estimator check failed");

// next-cycle implication, off during reset
`define RTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtt estimator check failed");

`endif

FILE: rtl/rtt_pkg.sv
// types and constants of the rtt estimator
// used by rtt_ctrl, rtt_dp and the top level
package rtt_pkg;

	localparam int TIME_BITS_DEF = 64;
	localparam int FULL_SIZE     = 1518;
	localparam int SCALE_BITS    = 11;
	localparam int QUOT_MAX      = 74;
	localparam logic [15:0] MIN_LEN_RST = 16'd3;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_REORDER = 3'd2,
		ST_LOST    = 3'd3,
		ST_ZERO    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DIV,
		S_SAT,
		S_DIFF,
		S_UPD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic sat;
		logic diff;
		logic upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic reject;
	} sts_t;

endpackage

FILE: rtl/rtt_ctrl.sv
// sequencer of the rtt estimator: handshakes, step order and divider count
// depends on rtt_pkg
module rtt_ctrl #(
	parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  rtt_pkg::sts_t sts,
	output rtt_pkg::cmd_t cmd
);
	import rtt_pkg::*;

	localparam int PW = TIME_BITS + SCALE_BITS - 1;
	localparam int CW = $clog2(PW + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= CW'(PW);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// result register: refilled only once the previous item has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.reject ? S_FIN : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = S_SAT;
				end
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/rtt_dp.sv
// datapath of the rtt estimator: checks, scaling, restoring divider,
// smoothed average and deviation, result register; depends on rtt_pkg
module rtt_dp #(
	parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rtt_pkg::cmd_t cmd,
	output rtt_pkg::sts_t sts,
	input  logic          cfg_valid,
	input  logic [15:0]   cfg_data,
	input  logic [15:0]   ack_length,
	input  logic          ack_reordered,
	input  logic          send_time_lost,
	input  logic [63:0]   recv_time,
	input  logic [63:0]   sent_time,
	input  logic [15:0]   packet_size,
	output logic [2:0]    status,
	output logic [63:0]   sample_rtt,
	output logic [63:0]   avg_rtt,
	output logic [63:0]   dev_rtt
);
	import rtt_pkg::*;

	localparam int HW = TIME_BITS - 1;
	localparam int PW = TIME_BITS + SCALE_BITS - 1;

	logic [15:0]    min_len_q;
	status_t        status_q;
	logic [HW-1:0]  half_q;
	logic [15:0]    size_q;
	logic [PW-1:0]  dvd_q;
	logic [15:0]    rem_q;
	logic [63:0]    sample_q;
	logic [63:0]    diff_q;
	logic [63:0]    avg_q;
	logic [63:0]    dev_q;
	logic [2:0]     out_status_q;
	logic [63:0]    out_sample_q;
	logic [63:0]    out_avg_q;
	logic [63:0]    out_dev_q;

	status_t              status_d;
	logic [TIME_BITS-1:0] delta;
	logic [16:0]          trial;
	logic                 qbit;
	logic [QUOT_MAX-1:0]  quot_ext;
	logic [65:0]          avg_sum;
	logic [66:0]          dev_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RST;
		end else if (cfg_valid) begin
			min_len_q <= cfg_data;
		end
	end

	always_comb begin
		if (ack_length < min_len_q) begin
			status_d = ST_SHORT;
		end else if (ack_reordered) begin
			status_d = ST_REORDER;
		end else if (send_time_lost) begin
			status_d = ST_LOST;
		end else if (packet_size == 16'd0) begin
			status_d = ST_ZERO;
		end else begin
			status_d = ST_OK;
		end
	end

	// time difference wraps at the timestamp width
	assign delta = recv_time[TIME_BITS-1:0] - sent_time[TIME_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= status_d;
			half_q   <= delta[TIME_BITS-1:1];
			size_q   <= packet_size;
		end
	end

	assign sts.reject = (status_q != ST_OK);

	// restoring division of half*1518 by the packet size, one bit a cycle
	assign trial = {rem_q, dvd_q[PW-1]} - {1'b0, size_q};
	assign qbit  = !trial[16];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dvd_q <= PW'(half_q) * PW'(FULL_SIZE);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[PW-2:0], qbit};
			rem_q <= qbit ? trial[15:0] : {rem_q[14:0], dvd_q[PW-1]};
		end
	end

	assign quot_ext = QUOT_MAX'(dvd_q);

	always_ff @(posedge clk) begin
		if (cmd.sat) begin
			sample_q <= (|quot_ext[QUOT_MAX-1:64]) ? '1 : quot_ext[63:0];
		end
		if (cmd.diff) begin
			diff_q <= (sample_q > avg_q) ? sample_q - avg_q : avg_q - sample_q;
		end
	end

	// floor((3*avg+sample)/4) and floor((7*dev+diff)/8) at full width
	assign avg_sum = {2'b00, avg_q} + {1'b0, avg_q, 1'b0} + {2'b00, sample_q};
	assign dev_sum = {dev_q, 3'b000} - {3'b000, dev_q} + {3'b000, diff_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			dev_q <= '0;
		end else if (cmd.upd) begin
			if (avg_q == 64'd0) begin
				avg_q <= sample_q;
			end else begin
				avg_q <= avg_sum[65:2];
				dev_q <= (dev_q == 64'd0) ? diff_q : dev_sum[66:3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_sample_q <= (status_q == ST_OK) ? sample_q : 64'd0;
			out_avg_q    <= avg_q;
			out_dev_q    <= dev_q;
		end
	end

	assign status     = out_status_q;
	assign sample_rtt = out_sample_q;
	assign avg_rtt    = out_avg_q;
	assign dev_rtt    = out_dev_q;

endmodule

FILE: rtl/rtt_ewma_estimator.sv
// top level of the rtt estimator: stream ports, configuration port
// instantiates rtt_ctrl and rtt_dp, depends on rtt_pkg
//
// one ack item enters on the s_ channel, one result item leaves on the m_ channel
// for every ack, in order. acks with a fault are answered with a nonzero status,
// a zero sample and the unchanged average and deviation.
// an accepted ack goes through the restoring divider, which takes one quotient
// bit per cycle over TIME_BITS + 10 bits; a rejected ack skips it. s_tready is
// high only while the sequencer is idle. the result sits in an output register,
// so the next ack is taken while a finished result still waits for m_tready. a
// stalled receiver holds the result and the finished next one waits in the
// datapath until the register frees. reset clears the average, the deviation
// and the valid flags, and sets the minimum ack length to 3. cfg_data is written
// whenever cfg_valid is high (cfg_ready stays high); write it only while no item
// is in flight.
module rtt_ewma_estimator #(
	parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,   // ack_length, recv_time, sent_time, packet_size
	input  logic [1:0]   s_tuser,   // ack_reordered, send_time_lost
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // sample_rtt, avg_rtt, dev_rtt
	output logic [2:0]   m_tuser,   // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data   // min_ack_length
);
	import rtt_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [63:0] sample_rtt;
	logic [63:0] avg_rtt;
	logic [63:0] dev_rtt;

	assign cfg_ready = 1'b1;

	rtt_ctrl #(
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtt_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.ack_length     (s_tdata[15:0]),
		.ack_reordered  (s_tuser[0]),
		.send_time_lost (s_tuser[1]),
		.recv_time      (s_tdata[79:16]),
		.sent_time      (s_tdata[143:80]),
		.packet_size    (s_tdata[159:144]),
		.status         (m_tuser),
		.sample_rtt     (sample_rtt),
		.avg_rtt        (avg_rtt),
		.dev_rtt        (dev_rtt)
	);

	assign m_tdata = {dev_rtt, avg_rtt, sample_rtt};

endmodule

FILE: rtl/rtt_checker.sv
// port-level checks of the rtt estimator, bound to the top level
// depends on rtt_ewma_estimator_macros.svh
`include "rtt_ewma_estimator_macros.svh"

module rtt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [2:0]   m_tuser
);
	import rtt_pkg::*;

	// a result waiting on the receiver stays offered
	`RTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	// a rejected ack carries no sample
	`RTT_ASSERT_SAME(a_reject_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[63:0] == 64'd0)
	// status codes stay within the defined set
	`RTT_ASSERT_SAME(a_status_range, m_tvalid, m_tuser <= ST_ZERO)
	// one ack at a time: busy right after an accept
	`RTT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind rtt_ewma_estimator rtt_checker u_rtt_checker (.*);

FILE: test/rtt_ewma_estimator_checker.sv
// checker for the rtt estimator: watches the ack, result and config channels,
// predicts each result and compares it with the result item; depends on rtt_pkg
module rtt_ewma_estimator_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,   // ack_length, recv_time, sent_time, packet_size
	input  logic [1:0]   s_tuser,   // ack_reordered, send_time_lost
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,   // sample_rtt, avg_rtt, dev_rtt
	input  logic [2:0]   m_tuser,   // status
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [15:0]  cfg_data,  // min_ack_length
	output int           mismatch_count,
	output int           outstanding
);
	import rtt_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [63:0] sample_rtt;
		logic [63:0] avg_rtt;
		logic [63:0] dev_rtt;
	} rtt_result_t;

	rtt_result_t pending_results[$];
	logic [63:0] est_avg;
	logic [63:0] est_dev;
	logic [15:0] min_len;

	// fault checks in priority order, then sample scaling and the smoothing update
	task automatic predict_ack(input logic [159:0] d, input logic [1:0] u,
			output rtt_result_t r);
		logic [15:0] len;
		logic [15:0] size;
		logic [63:0] half;
		logic [63:0] diff;
		logic [79:0] wide;
		len = d[15:0];
		size = d[159:144];
		half = (d[79:16] - d[143:80]) >> 1;
		r.sample_rtt = '0;
		if (len < min_len) begin
			r.status = ST_SHORT;
		end else if (u[0]) begin
			r.status = ST_REORDER;
		end else if (u[1]) begin
			r.status = ST_LOST;
		end else if (size == 16'd0) begin
			r.status = ST_ZERO;
		end else begin
			r.status = ST_OK;
			wide = ({16'd0, half} * 80'(FULL_SIZE)) / {64'd0, size};
			r.sample_rtt = (wide[79:64] != 16'd0) ? '1 : wide[63:0];
			if (est_avg == 64'd0) begin
				// first (or re-seeding) sample, deviation untouched
				est_avg = r.sample_rtt;
			end else begin
				diff = (r.sample_rtt > est_avg) ? r.sample_rtt - est_avg
					: est_avg - r.sample_rtt;
				if (est_dev == 64'd0) begin
					est_dev = diff;
				end else begin
					wide = ({16'd0, est_dev} * 80'd7 + {16'd0, diff}) >> 3;
					est_dev = wide[63:0];
				end
				wide = ({16'd0, est_avg} * 80'd3 + {16'd0, r.sample_rtt}) >> 2;
				est_avg = wide[63:0];
			end
		end
		r.avg_rtt = est_avg;
		r.dev_rtt = est_dev;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rtt_result_t got;
		rtt_result_t want;
		if (!arst_n) begin
			est_avg = '0;
			est_dev = '0;
			min_len = MIN_LEN_RST;
			pending_results.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				min_len = cfg_data;
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.sample_rtt = m_tdata[63:0];
				got.avg_rtt = m_tdata[127:64];
				got.dev_rtt = m_tdata[191:128];
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result item with none expected: status %0d sample %0h avg %0h dev %0h",
							$realtime, got.status, got.sample_rtt, got.avg_rtt, got.dev_rtt);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch exp status %0d sample %0h avg %0h dev %0h / got status %0d sample %0h avg %0h dev %0h",
								$realtime, want.status, want.sample_rtt, want.avg_rtt,
								want.dev_rtt, got.status, got.sample_rtt, got.avg_rtt,
								got.dev_rtt);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_ack(s_tdata, s_tuser, want);
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: test/rtt_ewma_estimator_tb.sv
// testbench top for the rtt estimator: clock, reset, ack and config stimulus,
// random receiver stalls, watchdog and verdict; uses rtt_ewma_estimator_checker
module rtt_ewma_estimator_tb;
	import rtt_pkg::*;

	localparam int IDLE_LIMIT     = 3000;
	localparam int RX_HOLD_CYCLES = 400;

	typedef struct {
		logic [15:0] len;
		logic        reord;
		logic        lost;
		logic [63:0] recv;
		logic [63:0] sent;
		logic [15:0] size;
	} ack_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;   // ack_length, recv_time, sent_time, packet_size
	logic [1:0]   s_tuser = '0;   // ack_reordered, send_time_lost
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;        // sample_rtt, avg_rtt, dev_rtt
	logic [2:0]   m_tuser;        // status
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;  // min_ack_length

	int          mismatch_count;
	int          outstanding;
	int          idle_cycles = 0;
	logic        rx_long_hold = 1'b0;
	logic [15:0] cur_min = MIN_LEN_RST;

	rtt_ewma_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	rtt_ewma_estimator_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly no gap, sometimes a short gap, rarely a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(120, 20);
	endfunction

	function automatic ack_t make_ack(input logic [15:0] len, input logic reord,
			input logic lost, input logic [63:0] recv, input logic [63:0] sent,
			input logic [15:0] size);
		ack_t a;
		a.len = len;
		a.reord = reord;
		a.lost = lost;
		a.recv = recv;
		a.sent = sent;
		a.size = size;
		return a;
	endfunction

	// entered and left at a falling edge
	task automatic send_ack(input ack_t a);
		int gap;
		s_tdata = {a.size, a.sent, a.recv, a.len};
		s_tuser = {a.lost, a.reord};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_min_len(input logic [15:0] value);
		wait_idle();
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_min = value;
	endtask

	// mostly well-formed acks with plausible timing, the rest noise with faults
	task automatic run_random(input int count);
		ack_t a;
		logic [63:0] delta;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 80) begin
				a.len = 16'($urandom_range(65535, cur_min));
				a.reord = 1'b0;
				a.lost = 1'b0;
				a.sent = {$urandom, $urandom};
				if ($urandom_range(99) < 85)
					delta = 64'($urandom_range(200000, 0));
				else
					delta = {$urandom, $urandom};
				a.recv = a.sent + delta;
				if ($urandom_range(99) < 80)
					a.size = 16'($urandom_range(1518, 1));
				else
					a.size = 16'($urandom_range(65535, 1));
			end else begin
				a.len = 16'($urandom);
				a.reord = ($urandom_range(2) == 0);
				a.lost = ($urandom_range(2) == 0);
				a.recv = {$urandom, $urandom};
				a.sent = {$urandom, $urandom};
				a.size = ($urandom_range(99) < 15) ? 16'd0 : 16'($urandom);
			end
			send_ack(a);
		end
	endtask

	// receiver: runs of ready and stalls, plus one long hold on request
	initial begin
		int rx_left;
		rx_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_long_hold) begin
				m_tready = 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_long_hold = 1'b0;
			end else if (rx_left > 0) begin
				rx_left--;
			end else if (m_tready) begin
				rx_left = pick_gap();
				if (rx_left > 0) begin
					m_tready = 1'b0;
					rx_left--;
				end else begin
					rx_left = $urandom_range(30, 0);
				end
			end else begin
				m_tready = 1'b1;
				rx_left = $urandom_range(30, 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fault priority and rejects at the reset minimum length
		send_ack(make_ack(16'd2, 1'b0, 1'b0, 64'd1000, 64'd0, 16'd1518));
		send_ack(make_ack(16'd0, 1'b1, 1'b1, 64'd1000, 64'd0, 16'd0));
		send_ack(make_ack(16'd3, 1'b1, 1'b1, 64'd1000, 64'd0, 16'd0));
		send_ack(make_ack(16'hFFFF, 1'b0, 1'b1, 64'd1000, 64'd0, 16'd0));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd1000, 64'd0, 16'd0));
		// zero first sample leaves the average unseeded
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd777, 64'd777, 16'd1518));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd1000, 64'd0, 16'd1518));
		// deviation seeded from the first difference
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd3000, 64'd1000, 16'd1518));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd400, 64'd0, 16'd1518));
		// receive before send wraps around
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd5, 64'hFFFF_FFFF_FFFF_FFF0, 16'd759));
		// rejected ack keeps the state
		send_ack(make_ack(16'd40, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'd1));
		// saturation of the scaled sample
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'd1));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'd1));
		send_ack(make_ack(16'hFFFF, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
			16'hFFFF));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd10, 64'd0, 16'hFFFF));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'h8000_0000_0000_0000, 64'd1, 16'd3));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd100, 64'd0, 16'd1));
		send_ack(make_ack(16'd40, 1'b0, 1'b0, 64'd2, 64'd0, 16'd1518));

		write_min_len(16'd0);
		run_random(150);

		// receiver holds off while acks keep coming, so the input stalls
		rx_long_hold = 1'b1;
		for (int i = 0; i < 12; i++)
			send_ack(make_ack(16'd100, 1'b0, 1'b0, 64'd50000 + i * 64'd37, 64'd0,
				16'($urandom_range(1518, 1))));

		write_min_len(16'hFFFF);
		run_random(60);
		write_min_len(16'($urandom_range(65534, 1)));
		run_random(150);
		write_min_len(16'd1518);
		run_random(200);

		wait_idle();
		repeat (100) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_ctrl.sv
rtl/rtt_dp.sv
rtl/rtt_ewma_estimator.sv
rtl/rtt_checker.sv
test/rtt_ewma_estimator_checker.sv
test/rtt_ewma_estimator_tb.sv
